// ===== rtl/csb_pkg.sv =====
// Shared types and constants for the counting semaphore bank.
package csb_pkg;

	localparam int NumSemsDef    = 8;
	localparam int MaxWaitersDef = 16;
	localparam int TaskIdBitsDef = 8;
	localparam int CountBitsDef  = 16;

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_WAIT    = 2'd1,
		MODE_SIGNAL  = 2'd2,
		MODE_DESTROY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_STATE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  sem_index;
		logic [7:0]  task_id;
		logic [15:0] init_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       blocked;
		logic       woken_valid;
		logic [7:0] woken_task;
		logic       woken_aborted;
		logic       last;
	} rsp_t;

	// classified request handed from the front part to the back part
	typedef struct packed {
		logic [1:0]  mode;
		logic        bad_index;
		logic [2:0]  sem_index;
		logic [7:0]  task_id;
		logic [15:0] init_value;
	} cmd_t;

endpackage

// ===== rtl/csb_front.sv =====
// Front part: takes requests, classifies the index, feeds a two-entry queue.
module csb_front #(
	parameter int NUM_SEMS = csb_pkg::NumSemsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          stall,
	input  csb_pkg::req_t req,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output csb_pkg::cmd_t cmd
);
	localparam logic [3:0] NumSemsW = 4'(NUM_SEMS);

	csb_pkg::cmd_t q_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	logic          push;
	csb_pkg::cmd_t nc;

	assign stall     = (cnt_q == 2'd2);
	assign push      = valid && !stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];

	always_comb begin
		nc.mode       = req.mode;
		nc.bad_index  = ({1'b0, req.sem_index} >= NumSemsW);
		nc.sem_index  = req.sem_index;
		nc.task_id    = req.task_id;
		nc.init_value = req.init_value;
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_take);
		end
	end

	always_ff @(posedge clk) begin
		if (!arst_n) begin
		end else begin
			assert (!(cmd_take && !cmd_valid))
				else $error("queue read while empty");
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_push_seen;
		@(posedge clk) disable iff (!arst_n)
			(push && !cmd_take && cnt_q == 2'd0) |=> cmd_valid;
	endproperty
	a_push_seen: assert property (p_push_seen) else $error("pushed request lost");

	property p_full_stalls;
		@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd2) |-> stall;
	endproperty
	a_full_stalls: assert property (p_full_stalls) else $error("full queue not stalling");
endmodule

// ===== rtl/csb_back.sv =====
// Back part: semaphore state, wait-slot memory and result sequencing.
module csb_back #(
	parameter int NUM_SEMS     = csb_pkg::NumSemsDef,
	parameter int MAX_WAITERS  = csb_pkg::MaxWaitersDef,
	parameter int TASK_ID_BITS = csb_pkg::TaskIdBitsDef,
	parameter int COUNT_BITS   = csb_pkg::CountBitsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  csb_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output csb_pkg::rsp_t rsp
);
	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int FW = $clog2(MAX_WAITERS + 1);
	localparam int DEPTH = NUM_SEMS * MAX_WAITERS;
	localparam logic [COUNT_BITS-1:0] CMax = {COUNT_BITS{1'b1}};
	localparam logic [FW-1:0] FMax = FW'(MAX_WAITERS);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t                  st_q;
	logic [NUM_SEMS-1:0]     live_q;
	logic [COUNT_BITS-1:0]   count_q [NUM_SEMS];
	logic [HW-1:0]           head_q  [NUM_SEMS];
	logic [FW-1:0]           fill_q  [NUM_SEMS];
	logic [TASK_ID_BITS-1:0] slots   [DEPTH];
	logic [TASK_ID_BITS-1:0] rd_data_q;
	csb_pkg::cmd_t           c_q;
	csb_pkg::rsp_t           out_q;
	logic                    out_v_q;
	logic                    rd_pend_q;

	logic [SW-1:0]           si;
	logic [SW-1:0]           rd_si;
	logic [COUNT_BITS-1:0]   cur_count;
	logic [HW-1:0]           cur_head;
	logic [FW-1:0]           cur_fill;
	logic [HW-1:0]           tail;
	logic [HW+FW:0]          tail_sum;
	logic [TASK_ID_BITS-1:0] tid;
	logic                    out_free;
	logic [7:0]              woken;
	logic                    load;
	logic                    drain_go;
	csb_pkg::rsp_t           rsp_n;

	assign si        = SW'(c_q.sem_index);
	// the head slot is read at the take edge for the incoming request
	assign rd_si     = cmd_take ? SW'(cmd.sem_index) : si;
	assign cur_count = count_q[si];
	assign cur_head  = head_q[si];
	assign cur_fill  = fill_q[si];
	assign tail_sum  = (HW+FW+1)'(cur_head) + (HW+FW+1)'(cur_fill);
	assign tid       = TASK_ID_BITS'(c_q.task_id);
	assign out_free  = !out_v_q || !rsp_stall;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign cmd_take  = (st_q == S_IDLE) && cmd_valid;
	assign woken     = 8'(rd_data_q);
	assign drain_go  = !c_q.bad_index && c_q.mode == csb_pkg::MODE_DESTROY &&
	                   live_q[si] && cur_fill != '0;

	always_comb begin
		if (tail_sum >= (HW+FW+1)'(MAX_WAITERS))
			tail = HW'(tail_sum - (HW+FW+1)'(MAX_WAITERS));
		else
			tail = HW'(tail_sum);
	end

	function automatic logic [HW-1:0] nxt(input logic [HW-1:0] h);
		logic [HW:0] t;
		t = {1'b0, h} + 1'b1;
		if (t >= (HW+1)'(MAX_WAITERS)) return '0;
		return t[HW-1:0];
	endfunction

	function automatic csb_pkg::rsp_t mk(input logic [1:0] s, input logic b);
		csb_pkg::rsp_t r;
		r = '0;
		r.status  = s;
		r.blocked = b;
		r.last    = 1'b1;
		return r;
	endfunction

	// result for this cycle, loaded into the output register when load is set
	always_comb begin
		load  = 1'b0;
		rsp_n = mk(csb_pkg::ST_OK, 1'b0);
		if (st_q == S_EXEC && out_free) begin
			if (c_q.bad_index) begin
				load  = 1'b1;
				rsp_n = mk(csb_pkg::ST_STATE, 1'b0);
			end else if (c_q.mode == csb_pkg::MODE_INIT) begin
				load  = 1'b1;
				rsp_n = live_q[si] ? mk(csb_pkg::ST_STATE, 1'b0) : mk(csb_pkg::ST_OK, 1'b0);
			end else if (!live_q[si]) begin
				load  = 1'b1;
				rsp_n = mk(csb_pkg::ST_STATE, 1'b0);
			end else if (c_q.mode == csb_pkg::MODE_WAIT) begin
				load = 1'b1;
				if (cur_count != '0) rsp_n = mk(csb_pkg::ST_OK, 1'b0);
				else if (cur_fill < FMax) rsp_n = mk(csb_pkg::ST_OK, 1'b1);
				else rsp_n = mk(csb_pkg::ST_FULL, 1'b0);
			end else if (c_q.mode == csb_pkg::MODE_SIGNAL) begin
				load = 1'b1;
				if (cur_fill != '0) begin
					rsp_n.woken_valid = 1'b1;
					rsp_n.woken_task  = woken;
				end
			end else if (cur_fill == '0) begin
				load = 1'b1;
			end
		end else if (st_q == S_DRAIN && out_free && rd_pend_q) begin
			load                = 1'b1;
			rsp_n.woken_valid   = 1'b1;
			rsp_n.woken_task    = woken;
			rsp_n.woken_aborted = 1'b1;
			rsp_n.last          = (cur_fill == FW'(1));
		end
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (st_q == S_EXEC && c_q.mode == csb_pkg::MODE_WAIT && !c_q.bad_index &&
		    live_q[si] && cur_count == '0 && cur_fill < FMax)
			slots[(SW+HW)'(si) * (SW+HW)'(MAX_WAITERS) + (SW+HW)'(tail)] <= tid;
		rd_data_q <= slots[(SW+HW)'(rd_si) * (SW+HW)'(MAX_WAITERS) +
			(SW+HW)'(head_q[rd_si])];
		if (cmd_take) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			live_q    <= '0;
			out_v_q   <= 1'b0;
			rd_pend_q <= 1'b0;
			out_q     <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
		end else begin
			out_v_q <= load || (out_v_q && rsp_stall);
			if (load) out_q <= rsp_n;
			case (st_q)
				S_IDLE: if (cmd_take) st_q <= S_EXEC;
				S_EXEC: if (out_free) begin
					// read data for the head slot is valid here
					st_q <= drain_go ? S_DRAIN : S_IDLE;
					if (!c_q.bad_index) begin
						if (c_q.mode == csb_pkg::MODE_INIT) begin
							if (!live_q[si]) begin
								live_q[si] <= 1'b1;
								count_q[si] <= (c_q.init_value > 16'(CMax)) ?
									CMax : COUNT_BITS'(c_q.init_value);
								head_q[si] <= '0;
								fill_q[si] <= '0;
							end
						end else if (live_q[si]) begin
							if (c_q.mode == csb_pkg::MODE_WAIT) begin
								if (cur_count != '0)
									count_q[si] <= cur_count - 1'b1;
								else if (cur_fill < FMax)
									fill_q[si] <= cur_fill + 1'b1;
							end else if (c_q.mode == csb_pkg::MODE_SIGNAL) begin
								if (cur_fill != '0) begin
									head_q[si] <= nxt(cur_head);
									fill_q[si] <= cur_fill - 1'b1;
								end else if (cur_count != CMax)
									count_q[si] <= cur_count + 1'b1;
							end else begin
								live_q[si]  <= 1'b0;
								count_q[si] <= '0;
								if (cur_fill == '0) head_q[si] <= '0;
								else rd_pend_q <= 1'b0;
							end
						end
					end
				end
				S_DRAIN: if (out_free) begin
					// one waiter per visit, re-reading head after each pop
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q  <= 1'b0;
						fill_q[si] <= cur_fill - 1'b1;
						if (cur_fill == FW'(1)) begin
							head_q[si] <= '0;
							st_q       <= S_IDLE;
						end else head_q[si] <= nxt(cur_head);
					end
				end
				S_OUT:   st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	property p_fill_bound;
		@(posedge clk) disable iff (!arst_n) fill_q[si] <= FMax;
	endproperty
	a_fill_bound: assert property (p_fill_bound) else $error("wait queue over capacity");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			(out_v_q && rsp_stall) |=> (out_v_q && $stable(out_q));
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

	property p_take_idle;
		@(posedge clk) disable iff (!arst_n) cmd_take |=> (st_q == S_EXEC);
	endproperty
	a_take_idle: assert property (p_take_idle) else $error("request not executed");
endmodule

// ===== rtl/counting_semaphore_bank.sv =====
// Top level of the counting semaphore bank.
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
// In the back part a request has its state read, then updated; a destroy with waiters
// then drains them, one memory read of the head slot per waiter.
// Reset clears every semaphore to dead with an empty queue.
// A two-entry queue lets requests be taken while a result is stalled.
module counting_semaphore_bank #(
	parameter int NUM_SEMS     = csb_pkg::NumSemsDef,
	parameter int MAX_WAITERS  = csb_pkg::MaxWaitersDef,
	parameter int TASK_ID_BITS = csb_pkg::TaskIdBitsDef,
	parameter int COUNT_BITS   = csb_pkg::CountBitsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  csb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output csb_pkg::rsp_t rsp
);
	logic          cmd_valid, cmd_take;
	csb_pkg::cmd_t cmd;

	csb_front #(.NUM_SEMS(NUM_SEMS)) u_front (
		.clk, .arst_n, .valid(req_valid), .stall(req_stall), .req,
		.cmd_valid, .cmd_take, .cmd
	);

	csb_back #(
		.NUM_SEMS(NUM_SEMS), .MAX_WAITERS(MAX_WAITERS),
		.TASK_ID_BITS(TASK_ID_BITS), .COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.rsp_valid, .rsp_stall, .rsp
	);
endmodule

// ===== tb/sv/csb_checker.sv =====
// Checker for the counting semaphore bank: predicts results of each request and compares.
module csb_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  csb_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  csb_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEM = csb_pkg::NumSemsDef;
	localparam int NWAIT = csb_pkg::MaxWaitersDef;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	logic          live [NSEM];
	logic [15:0]   cnt [NSEM];
	logic [3:0]    head [NSEM];
	logic [4:0]    fill [NSEM];
	logic [7:0]    slots [NSEM][NWAIT];
	csb_pkg::rsp_t expected_q [$];

	assign pending = expected_q.size();

	task automatic report(input string what, input csb_pkg::rsp_t got,
			input csb_pkg::rsp_t want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic csb_pkg::rsp_t mk(input csb_pkg::status_t st, input logic blk,
			input logic wv, input logic [7:0] wt, input logic wa, input logic lst);
		csb_pkg::rsp_t r;
		r.status = st;
		r.blocked = blk;
		r.woken_valid = wv;
		r.woken_task = wt;
		r.woken_aborted = wa;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_semaphore(input csb_pkg::req_t r);
		int s;
		logic [3:0] pos;
		s = r.sem_index;
		if (r.mode == csb_pkg::MODE_INIT) begin
			if (live[s]) expected_q.push_back(mk(csb_pkg::ST_STATE, 0, 0, 0, 0, 1));
			else begin
				live[s] = 1;
				cnt[s] = r.init_value;
				head[s] = 0;
				fill[s] = 0;
				expected_q.push_back(mk(csb_pkg::ST_OK, 0, 0, 0, 0, 1));
			end
		end else if (!live[s]) begin
			expected_q.push_back(mk(csb_pkg::ST_STATE, 0, 0, 0, 0, 1));
		end else if (r.mode == csb_pkg::MODE_WAIT) begin
			if (cnt[s] != 0) begin
				cnt[s]--;
				expected_q.push_back(mk(csb_pkg::ST_OK, 0, 0, 0, 0, 1));
			end else if (fill[s] < NWAIT) begin
				pos = head[s] + fill[s][3:0];
				slots[s][pos] = r.task_id;
				fill[s]++;
				expected_q.push_back(mk(csb_pkg::ST_OK, 1, 0, 0, 0, 1));
			end else expected_q.push_back(mk(csb_pkg::ST_FULL, 0, 0, 0, 0, 1));
		end else if (r.mode == csb_pkg::MODE_SIGNAL) begin
			if (fill[s] != 0) begin
				expected_q.push_back(mk(csb_pkg::ST_OK, 0, 1, slots[s][head[s]], 0, 1));
				head[s]++;
				fill[s]--;
			end else begin
				if (cnt[s] != CNT_MAX) cnt[s]++;
				expected_q.push_back(mk(csb_pkg::ST_OK, 0, 0, 0, 0, 1));
			end
		end else begin
			live[s] = 0;
			cnt[s] = 0;
			if (fill[s] == 0) expected_q.push_back(mk(csb_pkg::ST_OK, 0, 0, 0, 0, 1));
			while (fill[s] != 0) begin
				fill[s]--;
				expected_q.push_back(mk(csb_pkg::ST_OK, 0, 1, slots[s][head[s]], 1,
					fill[s] == 0));
				head[s]++;
			end
			head[s] = 0;
		end
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < NSEM; i++) begin
			live[i] = 0;
			cnt[i] = 0;
			head[i] = 0;
			fill[i] = 0;
		end
	end

	always @(posedge clk) begin
		csb_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", rsp, '0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status) report("status", rsp, want);
					if (rsp.blocked !== want.blocked) report("blocked", rsp, want);
					if (rsp.woken_valid !== want.woken_valid) report("woken_valid", rsp, want);
					if (rsp.woken_task !== want.woken_task) report("woken_task", rsp, want);
					if (rsp.woken_aborted !== want.woken_aborted)
						report("woken_aborted", rsp, want);
					if (rsp.last !== want.last) report("last", rsp, want);
				end
			end
			if (req_valid && !req_stall) predict_semaphore(req);
		end
	end
endmodule

// ===== tb/sv/tb_counting_semaphore_bank.sv =====
// Testbench top for the counting semaphore bank: stimulus, watchdog and verdict.
module tb_counting_semaphore_bank;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	csb_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	csb_pkg::rsp_t rsp;
	int            fail_count;
	int            pending;
	int            idle_cycles;
	logic          busy_phase;
	logic [2:0]    hot_sem;

	counting_semaphore_bank u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	csb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// busy_phase: long stretch with no idling on either side
	always @(negedge clk) begin
		rsp_stall <= busy_phase ? 1'b0 : ($urandom_range(99) < 23);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// called at a falling edge; leaves valid high after acceptance
	task automatic send(input csb_pkg::mode_t m, input logic [2:0] s, input logic [7:0] t,
			input logic [15:0] v);
		while (!busy_phase && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.mode <= m;
		req.sem_index <= s;
		req.task_id <= t;
		req.init_value <= v;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		csb_pkg::mode_t m;
		int p;
		p = $urandom_range(99);
		if (p < 10) m = csb_pkg::MODE_INIT;
		else if (p < 55) m = csb_pkg::MODE_WAIT;
		else if (p < 92) m = csb_pkg::MODE_SIGNAL;
		else m = csb_pkg::MODE_DESTROY;
		// mostly one busy semaphore, so queues fill and drain
		send(m, ($urandom_range(99) < 70) ? hot_sem : 3'($urandom_range(7)),
			8'($urandom), (p < 4) ? 16'($urandom) : 16'($urandom_range(3)));
	endtask

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		idle_cycles = 0;
		busy_phase = 0;
		hot_sem = 3'd5;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(csb_pkg::MODE_WAIT, 3'd0, 8'h00, 16'h0000);      // dead semaphore
		send(csb_pkg::MODE_SIGNAL, 3'd7, 8'hFF, 16'hFFFF);
		send(csb_pkg::MODE_DESTROY, 3'd1, 8'h00, 16'h0000);
		send(csb_pkg::MODE_INIT, 3'd7, 8'hFF, 16'hFFFF);      // count at maximum
		send(csb_pkg::MODE_SIGNAL, 3'd7, 8'h00, 16'h0000);    // saturates
		send(csb_pkg::MODE_WAIT, 3'd7, 8'hAA, 16'h0000);
		send(csb_pkg::MODE_INIT, 3'd7, 8'h00, 16'h1234);      // already live
		send(csb_pkg::MODE_DESTROY, 3'd7, 8'h00, 16'h0000);   // no waiters
		send(csb_pkg::MODE_INIT, 3'd0, 8'h00, 16'h0001);
		send(csb_pkg::MODE_WAIT, 3'd0, 8'h55, 16'hFFFF);
		for (int i = 0; i < 17; i++)                          // fill, then one over
			send(csb_pkg::MODE_WAIT, 3'd0, 8'(i * 15 + 1), 16'h0000);
		send(csb_pkg::MODE_SIGNAL, 3'd0, 8'h00, 16'h0000);    // wake oldest
		send(csb_pkg::MODE_DESTROY, 3'd0, 8'h00, 16'h0000);   // releases fifteen

		for (int i = 0; i < 125; i++) begin
			busy_phase = (i >= 50 && i < 80);
			if (i % 40 == 0) hot_sem = 3'($urandom_range(7));
			send_random();
		end
		req_valid <= 1'b0;
		busy_phase = 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
